@@ hw/rtl/mer_pkg.sv @@
// Shared types and constants for the midpoint ellipse rasterizer.
package mer_pkg;
   localparam int CFG_BITS   = 13;
   localparam int CX_BITS    = 12;
   localparam int AXIS_BITS  = 11;
   localparam int INDEX_BITS = 24;
   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   typedef struct packed {
      logic                 action;
      logic [CX_BITS-1:0]   center_x;
      logic [CX_BITS-1:0]   center_y;
      logic [AXIS_BITS-1:0] semi_axis_a;
      logic [AXIS_BITS-1:0] semi_axis_b;
   } req_type;

   typedef struct packed {
      logic                  paint;
      logic [INDEX_BITS-1:0] pixel_index;
      logic                  last;
      logic                  done_res;
   } rsp_type;

   typedef struct packed {
      logic           index;
      logic [31:0]    data;
   } csr_type;
endpackage

@@ hw/rtl/mer_if.sv @@
// Valid/ready channel interface carrying one payload word.
interface mer_if #(parameter type PAYLOAD_TYPE = logic) (input logic clock);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/mer_front.sv @@
// Front end: input skid queue of two request words.
module mer_front
   import mer_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_word,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_word
);
   req_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in;
   logic push, pop;
   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_word  = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = pop ? ~rd_ff : rd_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
      if (push) q_ff[rd_ff ^ (cnt_ff != 2'd0)] <= in_word;
   end
endmodule

@@ hw/rtl/mer_div.sv @@
// Restoring divider, one quotient bit per cycle.
module mer_div #(parameter int BITS = 48) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [BITS-1:0] dividend,
   input  logic [BITS-1:0] divisor,
   output logic            busy,
   output logic [BITS-1:0] quotient
);
   localparam int CB = $clog2(BITS + 1);
   logic [BITS-1:0] q_ff, q_in, d_ff, d_in;
   logic [BITS:0]   r_ff, r_in, trial;
   logic [CB-1:0]   n_ff, n_in;
   assign busy = n_ff != '0;
   assign quotient = q_ff;
   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; n_in = n_ff;
      trial = {r_ff[BITS-1:0], q_ff[BITS-1]};
      if (start) begin
         q_in = dividend; d_in = divisor; r_in = '0; n_in = CB'(BITS);
      end else if (busy) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[BITS-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[BITS-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) n_ff <= '0;
      else n_ff <= n_in;
      q_ff <= q_in; d_ff <= d_in; r_ff <= r_in;
   end
endmodule

@@ hw/rtl/mer_back.sv @@
// Back end: ellipse state, part setup sequencer and pixel emission.
module mer_back
   import mer_pkg::*;
#(
   parameter int COORD_BITS    = 12,
   parameter int DECISION_BITS = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CFG_BITS-1:0] image_width,
   input  logic [CFG_BITS-1:0] image_height,
   input  logic                in_valid,
   output logic                in_ready,
   input  req_type             in_word,
   output logic                out_valid,
   input  logic                out_ready,
   output rsp_type             out_word
);
   localparam int DB = DECISION_BITS;
   localparam int CB = COORD_BITS;
   localparam int PB = 28;   // plotted coordinate / index arithmetic width
   typedef enum logic [3:0] {
      S_IDLE, S_M1, S_M2, S_M3, S_DIV, S_DWAIT, S_CHK, S_SQ, S_EMIT
   } state_type;
   state_type st_ff, st_in;

   logic busy_ff, second_ff;
   logic signed [CB-1:0] px_ff, py_ff;
   logic signed [DB-1:0] dec_ff, sa_ff, sb_ff;
   logic [DB-1:0] lim_ff;
   logic [CX_BITS-1:0] cx_ff, cy_ff;
   logic [AXIS_BITS-1:0] ha_ff, hb_ff;
   logic [2*AXIS_BITS-1:0] a2_ff, b2_ff;
   logic [3*AXIS_BITS-1:0] ba2_ff;
   logic [4*AXIS_BITS-1:0] a4_ff;
   logic [2*CB-1:0] sq_ff;
   logic done_ff, idle_rsp_ff;
   logic [1:0] k_ff;
   logic signed [PB-1:0] row_ff, prod_ff;
   logic signed [PB-1:0] plx_ff, ply_ff;
   logic left_ff, right_ff;
   logic [2*CFG_BITS-1:0] total_ff;

   logic [AXIS_BITS-1:0] pa, pb;
   logic div_start, div_busy;
   logic [DB-1:0] div_q, a2b2;
   logic signed [2*CB-1:0] px_wide;
   assign pa = second_ff ? ha_ff : hb_ff;
   assign pb = second_ff ? hb_ff : ha_ff;
   assign a2b2 = DB'(a2_ff) + DB'(b2_ff);
   assign div_start = st_ff == S_DIV;
   assign px_wide = (2*CB)'(px_ff);

   mer_div #(.BITS(DB)) u_div (
      .clock, .reset, .start(div_start), .dividend(DB'(a4_ff)), .divisor(a2b2),
      .busy(div_busy), .quotient(div_q));

   assign in_ready  = st_ff == S_IDLE;
   assign out_valid = st_ff == S_EMIT;

   // emission of pixel k
   logic signed [PB-1:0] col, idx;
   logic ok, paint;
   always_comb begin
      col = k_ff[0] ? PB'(cx_ff) - plx_ff : PB'(cx_ff) + plx_ff;
      ok  = k_ff[0] ? left_ff : right_ff;
      idx = prod_ff + col;
      paint = !idle_rsp_ff && ok && idx >= 0 && idx < $signed({2'b0, total_ff}) &&
              idx < $signed(PB'(1) <<< INDEX_BITS);
      out_word.paint       = paint;
      out_word.pixel_index = paint ? idx[INDEX_BITS-1:0] : '0;
      out_word.last        = idle_rsp_ff || k_ff == 2'd3;
      out_word.done_res    = done_ff;
   end

   logic signed [PB-1:0] rowk;
   assign rowk = k_ff[1] ? PB'(cy_ff) - ply_ff : PB'(cy_ff) + ply_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; busy_ff <= 1'b0; second_ff <= 1'b0;
         px_ff <= '0; py_ff <= '0; dec_ff <= '0; sa_ff <= '0; sb_ff <= '0;
         lim_ff <= '0; cx_ff <= '0; cy_ff <= '0; ha_ff <= '0; hb_ff <= '0;
      end else begin
         case (st_ff)
            S_IDLE: if (in_valid) begin
               if (in_word.action == ACT_START) begin
                  cx_ff <= in_word.center_x; cy_ff <= in_word.center_y;
                  ha_ff <= in_word.semi_axis_a; hb_ff <= in_word.semi_axis_b;
                  second_ff <= 1'b0; busy_ff <= 1'b1;
                  st_ff <= S_M1;
               end else if (!busy_ff) begin
                  idle_rsp_ff <= 1'b1; done_ff <= 1'b1; k_ff <= 2'd3;
                  st_ff <= S_EMIT;
               end else begin
                  idle_rsp_ff <= 1'b0; done_ff <= 1'b0;
                  sq_ff <= px_wide * px_wide;
                  plx_ff <= second_ff ? PB'(py_ff) : PB'(px_ff);
                  ply_ff <= second_ff ? PB'(px_ff) : PB'(py_ff);
                  st_ff <= S_SQ;
               end
            end
            // setup: square the axes, then products, then the initial decision terms, then divide
            S_M1: begin
               a2_ff <= pa * pa; b2_ff <= pb * pb; st_ff <= S_M2;
            end
            S_M2: begin
               ba2_ff <= pb * a2_ff;
               a4_ff <= a2_ff * a2_ff;
               st_ff <= S_M3;
            end
            S_M3: begin
               dec_ff <= DB'(4 * {DB'(b2_ff)} - 4 * DB'(ba2_ff) + DB'(a2_ff));
               sa_ff  <= DB'(12 * DB'(b2_ff));
               sb_ff  <= DB'(12 * DB'(b2_ff) - 8 * DB'(ba2_ff) + 8 * DB'(a2_ff));
               px_ff  <= '0;
               py_ff  <= CB'(pb);
               st_ff  <= S_DIV;
            end
            S_DIV: st_ff <= S_DWAIT;
            S_DWAIT: if (!div_busy) begin
               lim_ff <= (a2b2 == '0) ? '0 : div_q;
               st_ff <= S_IDLE;
            end
            S_SQ: begin
               left_ff  <= $signed(PB'(cx_ff)) - plx_ff >= 0;
               right_ff <= $signed(PB'(cx_ff)) + plx_ff < $signed(PB'(image_width));
               total_ff <= image_width * image_height;
               k_ff <= 2'd0;
               if (DB'(sq_ff) >= lim_ff) begin
                  if (second_ff) begin
                     busy_ff <= 1'b0; done_ff <= 1'b1; st_ff <= S_CHK;
                  end else begin
                     second_ff <= 1'b1; st_ff <= S_CHK;
                  end
               end else begin
                  if (dec_ff > 0) begin
                     dec_ff <= dec_ff + sb_ff;
                     sb_ff  <= sb_ff + DB'(8 * DB'(b2_ff)) + DB'(8 * DB'(a2_ff));
                     py_ff  <= py_ff - 1'b1;
                  end else begin
                     dec_ff <= dec_ff + sa_ff;
                     sb_ff  <= sb_ff + DB'(8 * DB'(b2_ff));
                  end
                  sa_ff <= sa_ff + DB'(8 * DB'(b2_ff));
                  px_ff <= px_ff + 1'b1;
                  st_ff <= S_CHK;
               end
            end
            S_CHK: begin
               row_ff  <= rowk;
               prod_ff <= PB'(rowk * $signed({1'b0, image_width}));
               st_ff <= S_EMIT;
            end
            S_EMIT: if (out_ready) begin
               if (out_word.last) begin
                  st_ff <= (second_ff && busy_ff && idle_rsp_ff == 1'b0
                            && !done_ff && sq_ff >= (2*CB)'(lim_ff)) ? S_M1 : S_IDLE;
               end else begin
                  k_ff <= k_ff + 1'b1;
                  st_ff <= S_CHK;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
   logic unused;
   assign unused = ^row_ff;
endmodule

@@ hw/rtl/midpoint_ellipse_raster.sv @@
// Top level of the midpoint ellipse rasterizer.
//  channel | dir | word
//  req_    | in  | action, center, semi-axes
//  rsp_    | out | paint, pixel_index, last, done_res
//  csr_    | in  | register index, write data
// A step: accept, square, then a check and an emit state per pixel word; an idle step emits one word.
// A start: accept, three multiply stages, divider launch, then a wait for the divider.
// A part switch reruns the setup from the multiply stages after its step. A stalled rsp_ holds the word.
// Reset is synchronous; registers return to 640 by 480.
// A two-word queue in front decouples the request side from a stalled rsp_.
module midpoint_ellipse_raster
   import mer_pkg::*;
#(
   parameter int COORD_BITS    = 12,
   parameter int DECISION_BITS = 48
) (
   input logic clock,
   input logic reset,
   mer_if.sink   req,
   mer_if.source rsp,
   mer_if.sink   csr
);
   logic [CFG_BITS-1:0] w_ff, h_ff;
   logic fv, fr;
   req_type fw;
   csr_type cw;
   assign cw = csr.payload;
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= WIDTH_RESET; h_ff <= HEIGHT_RESET;
      end else if (csr.valid) begin
         case (cw.index)
            REG_WIDTH:  w_ff <= cw.data[CFG_BITS-1:0];
            REG_HEIGHT: h_ff <= cw.data[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end
   mer_front u_front (.clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .in_word(req.payload), .out_valid(fv), .out_ready(fr), .out_word(fw));
   mer_back #(.COORD_BITS(COORD_BITS), .DECISION_BITS(DECISION_BITS)) u_back (
      .clock, .reset, .image_width(w_ff), .image_height(h_ff),
      .in_valid(fv), .in_ready(fr), .in_word(fw),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_word(rsp.payload));
endmodule
